### rtl/csa_pkg.sv
// shared types, constants and codes of the contiguous slot allocator
// no dependencies
package csa_pkg;

    localparam int SLOTS     = 256;
    localparam int OWNER_IDS = 255;

    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int STEP_W    = $clog2(SLOTS + 2);

    localparam int OWNER_W   = 8;
    localparam int SIZE_W    = 9;
    localparam int POL_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 9;
    localparam int STATUS_W  = 2;
    localparam int START_W   = 8;

    localparam logic [CFG_W-1:0] SLOTS_IN_USE_RESET = CFG_W'(256);

    localparam logic [CFG_IDX_W-1:0] REG_POLICY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS  = CFG_IDX_W'(1);

    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;
    localparam logic [POL_W-1:0] POL_NEXT  = 2'd3;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ALLOC    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic               cmd;
        logic [SIZE_W-1:0]  size;
        logic [OWNER_W-1:0] owner;
    } req_t;

    typedef struct packed {
        logic [POL_W-1:0] policy;
        logic [CNT_W-1:0] n;
    } cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    start;
    } res_t;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   addr;
        logic [OWNER_W-1:0] data;
    } mem_wr_t;

endpackage

### rtl/csa_if.sv
// request and result channel interfaces of the slot allocator
// depends on csa_pkg
interface csa_req_if;
    import csa_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [SIZE_W-1:0]  request_size;
    logic [OWNER_W-1:0] owner_id;

    modport source (output valid, output cmd, output request_size, output owner_id,
                    input ready);
    modport sink   (input valid, input cmd, input request_size, input owner_id,
                    output ready);
endinterface

interface csa_rsp_if;
    import csa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  start_slot;

    modport source (output valid, output status, output start_slot, input ready);
    modport sink   (input valid, input status, input start_slot, output ready);
endinterface

### rtl/contiguous_slot_allocator_core.sv
// top level of the contiguous slot allocator: config registers, result register
// depends on csa_pkg, csa_if, csa_slot_mem and csa_ctrl
//
// Owner map allocator over SLOTS slots with first, best, worst and next fit placement.
// After reset the map is cleared one slot a cycle, and the request channel stays
// not ready until the clear pass ends; configuration writes are taken meanwhile. Requests
// are handled one at a time. A release reads every managed slot once through the map's
// single read port; the managed slots are the first n, where n is the clamped slots_in_use.
// An allocate scans the map the same way, stopping early on a first fit, an exact best fit
// or a next fit hit, then writes the granted run one slot a cycle through the single write
// port. A rejected request skips the map and goes straight to its result. The result sits
// in an output register, so the next request is taken while it waits.
module contiguous_slot_allocator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    csa_req_if.sink                         req,
    csa_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [csa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [csa_pkg::CFG_W-1:0]       cfg_wdata
);
    import csa_pkg::*;

    logic [POL_W-1:0]    policy_reg, policy_next;
    logic [CFG_W-1:0]    slots_reg, slots_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [START_W-1:0]  out_start_reg, out_start_next;

    req_t                req_bus;
    cfg_t                cfg_bus;
    res_t                res_bus;
    mem_wr_t             mem_wr;
    logic [IDX_W-1:0]    mem_raddr;
    logic [OWNER_W-1:0]  mem_rdata;
    logic                idle;
    logic                res_valid;
    logic                req_take;
    logic                res_take;

    assign req_take = req.valid && idle;
    assign res_take = res_valid && (!out_valid_reg || rsp.ready);
    assign req.ready = idle;

    assign req_bus = '{cmd: req.cmd, size: req.request_size, owner: req.owner_id};
    assign cfg_bus = '{policy: policy_reg,
                       n: (32'(slots_reg) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(slots_reg)};

    always_comb
    begin
        policy_next = policy_reg;
        slots_next  = slots_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POLICY: policy_next = cfg_wdata[POL_W-1:0];
                REG_SLOTS:  slots_next  = cfg_wdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        if (res_take)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_bus.status;
            out_start_next  = (res_bus.status == ST_ALLOC) ? START_W'(res_bus.start) : '0;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POL_FIRST;
            slots_reg     <= SLOTS_IN_USE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            policy_reg    <= policy_next;
            slots_reg     <= slots_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.start_slot = out_start_reg;

    csa_slot_mem u_mem (
        .clk   (clk),
        .wr    (mem_wr),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    csa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_take  (req_take),
        .req       (req_bus),
        .cfg       (cfg_bus),
        .idle      (idle),
        .res_valid (res_valid),
        .res       (res_bus),
        .res_take  (res_take),
        .mem_wr    (mem_wr),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule

### rtl/csa_slot_mem.sv
// owner map storage: one write port, one read port with registered read data
// depends on csa_pkg
module csa_slot_mem (
    input  logic                             clk,
    input  csa_pkg::mem_wr_t                 wr,
    input  logic [csa_pkg::IDX_W-1:0]        raddr,
    output logic [csa_pkg::OWNER_W-1:0]      rdata
);
    import csa_pkg::*;

    logic [OWNER_W-1:0] mem [SLOTS];
    logic [OWNER_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/csa_ctrl.sv
// sequencer: clear pass, hole scan, run fill and owner release over the map
// depends on csa_pkg and drives csa_slot_mem
module csa_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_take,
    input  csa_pkg::req_t               req,
    input  csa_pkg::cfg_t               cfg,
    output logic                        idle,
    output logic                        res_valid,
    output csa_pkg::res_t               res,
    input  logic                        res_take,
    output csa_pkg::mem_wr_t            mem_wr,
    output logic [csa_pkg::IDX_W-1:0]   mem_raddr,
    input  logic [csa_pkg::OWNER_W-1:0] mem_rdata
);
    import csa_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_REL   = 6'b001000,
        S_FILL  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                cmd_reg, cmd_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [OWNER_W-1:0]  owner_reg, owner_next;
    logic [POL_W-1:0]    pol_reg, pol_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [IDX_W-1:0]    nfp_reg, nfp_next;
    logic [STEP_W-1:0]   iss_cnt_reg, iss_cnt_next;
    logic [IDX_W-1:0]    iss_pos_reg, iss_pos_next;
    logic                prc_vld_reg, prc_vld_next;
    logic [STEP_W-1:0]   prc_step_reg, prc_step_next;
    logic [IDX_W-1:0]    prc_pos_reg, prc_pos_next;
    logic [CNT_W-1:0]    run_len_reg, run_len_next;
    logic [IDX_W-1:0]    run_start_reg, run_start_next;
    logic                have_reg, have_next;
    logic [IDX_W-1:0]    pick_reg, pick_next;
    logic [CNT_W-1:0]    pick_len_reg, pick_len_next;
    logic                found_reg, found_next;
    logic [CNT_W-1:0]    fill_cnt_reg, fill_cnt_next;
    logic [IDX_W-1:0]    fill_pos_reg, fill_pos_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_start_reg, res_start_next;

    logic                nf;
    logic                issue;
    logic [STEP_W-1:0]   steps_total;
    logic                last;
    logic                slot_free;
    logic [IDX_W-1:0]    cur_idx;
    logic [CNT_W-1:0]    run_len_inc;
    logic                hit;
    logic [IDX_W-1:0]    hit_start;
    logic                owner_ok;
    logic [IDX_W-1:0]    p_eff;
    logic [CNT_W:0]      nf_sum;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] pos,
                                                  input logic [CNT_W-1:0] lim);
        logic [CNT_W:0] inc;
        inc = (CNT_W+1)'(pos) + (CNT_W+1)'(1);
        return (inc >= (CNT_W+1)'(lim)) ? '0 : IDX_W'(inc);
    endfunction

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        cmd_next        = cmd_reg;
        size_next       = size_reg;
        owner_next      = owner_reg;
        pol_next        = pol_reg;
        n_next          = n_reg;
        nfp_next        = nfp_reg;
        iss_cnt_next    = iss_cnt_reg;
        iss_pos_next    = iss_pos_reg;
        run_len_next    = run_len_reg;
        run_start_next  = run_start_reg;
        have_next       = have_reg;
        pick_next       = pick_reg;
        pick_len_next   = pick_len_reg;
        found_next      = found_reg;
        fill_cnt_next   = fill_cnt_reg;
        fill_pos_next   = fill_pos_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        mem_wr          = '0;
        hit             = 1'b0;
        hit_start       = run_start_reg;

        nf          = (pol_reg == POL_NEXT);
        steps_total = (nf || cmd_reg == CMD_RELEASE) ? STEP_W'(n_reg)
                                                     : STEP_W'(n_reg) + STEP_W'(1);
        issue       = (state_reg == S_SCAN || state_reg == S_REL)
                      && (iss_cnt_reg < steps_total);
        last        = (prc_step_reg == steps_total - STEP_W'(1));
        cur_idx     = nf ? prc_pos_reg : IDX_W'(prc_step_reg);
        slot_free   = ((CNT_W+1)'(prc_step_reg) < (CNT_W+1)'(n_reg)) && (mem_rdata == '0);
        run_len_inc = run_len_reg + CNT_W'(1);
        owner_ok    = (req.owner != '0) && (32'(req.owner) <= 32'(OWNER_IDS));
        p_eff       = ((CNT_W+1)'(nfp_reg) >= (CNT_W+1)'(cfg.n)) ? '0 : nfp_reg;
        nf_sum      = (CNT_W+1)'(res_start_reg) + (CNT_W+1)'(size_reg);
        if (nf_sum >= (CNT_W+1)'(n_reg))
        begin
            nf_sum = nf_sum - (CNT_W+1)'(n_reg);
        end

        if (issue)
        begin
            iss_cnt_next = iss_cnt_reg + STEP_W'(1);
            iss_pos_next = wrap_inc(iss_pos_reg, n_reg);
        end
        prc_vld_next  = issue;
        prc_step_next = iss_cnt_reg;
        prc_pos_next  = iss_pos_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_wr       = '{we: 1'b1, addr: clr_cnt_reg, data: '0};
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (32'(clr_cnt_reg) == SLOTS - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_take)
                begin
                    cmd_next       = req.cmd;
                    size_next      = req.size;
                    owner_next     = req.owner;
                    pol_next       = cfg.policy;
                    n_next         = cfg.n;
                    iss_cnt_next   = '0;
                    iss_pos_next   = (cfg.policy == POL_NEXT && req.cmd == CMD_ALLOC)
                                     ? p_eff : '0;
                    run_len_next   = '0;
                    have_next      = 1'b0;
                    found_next     = 1'b0;
                    res_start_next = '0;
                    if (req.cmd == CMD_RELEASE)
                    begin
                        if (!owner_ok || cfg.n == '0)
                        begin
                            res_status_next = ST_NOTFOUND;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_REL;
                        end
                    end
                    else if (!owner_ok || req.size == '0
                             || 32'(req.size) > 32'(cfg.n))
                    begin
                        res_status_next = ST_NOSPACE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (prc_vld_reg)
                begin
                    if (slot_free)
                    begin
                        if (run_len_reg == '0)
                        begin
                            run_start_next = cur_idx;
                        end
                        run_len_next = run_len_inc;
                        if (nf && 32'(run_len_inc) >= 32'(size_reg))
                        begin
                            hit       = 1'b1;
                            hit_start = (run_len_reg == '0) ? cur_idx : run_start_reg;
                        end
                    end
                    else
                    begin
                        run_len_next = '0;
                        if (!nf && 32'(run_len_reg) >= 32'(size_reg))
                        begin
                            priority if (pol_reg == POL_FIRST)
                            begin
                                hit = 1'b1;
                            end
                            else if (pol_reg == POL_BEST)
                            begin
                                if (32'(run_len_reg) == 32'(size_reg))
                                begin
                                    hit = 1'b1;
                                end
                                else if (!have_reg || run_len_reg < pick_len_reg)
                                begin
                                    have_next     = 1'b1;
                                    pick_next     = run_start_reg;
                                    pick_len_next = run_len_reg;
                                end
                            end
                            else
                            begin
                                if (!have_reg || run_len_reg > pick_len_reg)
                                begin
                                    have_next     = 1'b1;
                                    pick_next     = run_start_reg;
                                    pick_len_next = run_len_reg;
                                end
                            end
                        end
                    end
                    if (hit)
                    begin
                        fill_pos_next  = hit_start;
                        res_start_next = hit_start;
                        fill_cnt_next  = '0;
                        state_next     = S_FILL;
                    end
                    else if (last)
                    begin
                        if (have_next)
                        begin
                            fill_pos_next  = pick_next;
                            res_start_next = pick_next;
                            fill_cnt_next  = '0;
                            state_next     = S_FILL;
                        end
                        else
                        begin
                            res_status_next = ST_NOSPACE;
                            res_start_next  = '0;
                            state_next      = S_DONE;
                        end
                    end
                end
            end
            S_REL:
            begin
                if (prc_vld_reg)
                begin
                    if (mem_rdata == owner_reg)
                    begin
                        mem_wr     = '{we: 1'b1, addr: prc_pos_reg, data: '0};
                        found_next = 1'b1;
                    end
                    if (last)
                    begin
                        res_status_next = found_next ? ST_RELEASED : ST_NOTFOUND;
                        res_start_next  = '0;
                        state_next      = S_DONE;
                    end
                end
            end
            S_FILL:
            begin
                mem_wr        = '{we: 1'b1, addr: fill_pos_reg, data: owner_reg};
                fill_cnt_next = fill_cnt_reg + CNT_W'(1);
                fill_pos_next = wrap_inc(fill_pos_reg, n_reg);
                if (32'(fill_cnt_reg) + 1 == 32'(size_reg))
                begin
                    if (nf)
                    begin
                        nfp_next = IDX_W'(nf_sum);
                    end
                    res_status_next = ST_ALLOC;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            nfp_reg     <= '0;
            prc_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            nfp_reg     <= nfp_next;
            prc_vld_reg <= prc_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        size_reg       <= size_next;
        owner_reg      <= owner_next;
        pol_reg        <= pol_next;
        n_reg          <= n_next;
        iss_cnt_reg    <= iss_cnt_next;
        iss_pos_reg    <= iss_pos_next;
        prc_step_reg   <= prc_step_next;
        prc_pos_reg    <= prc_pos_next;
        run_len_reg    <= run_len_next;
        run_start_reg  <= run_start_next;
        have_reg       <= have_next;
        pick_reg       <= pick_next;
        pick_len_reg   <= pick_len_next;
        found_reg      <= found_next;
        fill_cnt_reg   <= fill_cnt_next;
        fill_pos_reg   <= fill_pos_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = '{status: res_status_reg, start: res_start_reg};
    assign mem_raddr = iss_pos_reg;

endmodule

### rtl/csa_checker.sv
// port level checks of the slot allocator and the bind that attaches them
// depends on csa_pkg and contiguous_slot_allocator_core
module csa_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               req_valid,
    input logic                               req_ready,
    input logic                               rsp_valid,
    input logic                               rsp_ready,
    input logic [csa_pkg::STATUS_W-1:0]       rsp_status,
    input logic [csa_pkg::START_W-1:0]        rsp_start_slot
);
    import csa_pkg::*;

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                    && $stable(rsp_start_slot))
        else $error("result changed while stalled");

    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_ALLOC |-> rsp_start_slot == '0)
        else $error("start slot set without a grant");

    // one request at a time
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // clear pass follows reset
    a_reset_not_ready: assert property (@(posedge clk)
        !rst_n |=> !req_ready)
        else $error("ready during map clear");

endmodule

bind contiguous_slot_allocator_core csa_checker u_csa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_start_slot (rsp.start_slot)
);

### tb/sv/contiguous_slot_allocator_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the contiguous slot allocator: directed and random requests
// over several register settings, each reply checked against an owner map kept here
// depends on csa_pkg, csa_if and contiguous_slot_allocator_core
module contiguous_slot_allocator_core_tb;
    import csa_pkg::*;

    localparam int CYCLE_LIMIT  = 1500000;
    localparam int SETTLE_LIMIT = 2 * SLOTS + 16;
    localparam int HOLD_CYCLES  = 4000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    typedef enum logic [1:0] {STEP_REQ, STEP_CFG, STEP_DRAIN} step_kind_t;

    typedef struct packed {
        step_kind_t            kind;
        req_t                  item;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_W-1:0]      value;
    } plan_step_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    csa_req_if req_ch ();
    csa_rsp_if rsp_ch ();

    contiguous_slot_allocator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // allocator state as predicted here
    logic [OWNER_W-1:0] owner_map [SLOTS];
    int unsigned        fit_ptr;
    logic [POL_W-1:0]   cur_policy;
    logic [CFG_W-1:0]   cur_slots;

    plan_step_t  queued_steps [$];
    res_t        predicted_replies [$];
    int unsigned live_owners [$];

    int unsigned req_sent;
    int unsigned req_taken;
    int unsigned replies_seen;
    int unsigned settings_used;
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned n_granted;
    int unsigned n_nospace;
    int unsigned n_released;
    int unsigned n_notfound;

    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned hold_left;
    logic        hold_done;
    int unsigned stall_left;
    int unsigned stall_mode;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic res_t serve_request(req_t r);
        int unsigned n;
        int unsigned pick;
        int unsigned pick_len;
        int unsigned run_start;
        int unsigned run_len;
        int unsigned cnt;
        int unsigned pos;
        int unsigned p;
        logic        owner_ok;
        logic        found;
        logic        have;
        logic        done;
        logic        free_slot;
        res_t        res;
        n = (cur_slots > SLOTS) ? SLOTS : cur_slots;
        owner_ok = (r.owner != 0) && (r.owner <= OWNER_IDS);
        res = '0;
        if (r.cmd == CMD_RELEASE)
        begin
            found = 1'b0;
            if (owner_ok)
            begin
                for (int i = 0; i < n; i++)
                begin
                    if (owner_map[i] == r.owner)
                    begin
                        owner_map[i] = '0;
                        found = 1'b1;
                    end
                end
            end
            res.status = found ? ST_RELEASED : ST_NOTFOUND;
        end
        else if (!owner_ok || r.size == 0 || r.size > n)
        begin
            res.status = ST_NOSPACE;
        end
        else
        begin
            have = 1'b0;
            done = 1'b0;
            pick = 0;
            pick_len = 0;
            run_start = 0;
            run_len = 0;
            if (cur_policy == POL_NEXT)
            begin
                // circular scan, a run may cross the last managed slot
                p = (fit_ptr >= n) ? 0 : fit_ptr;
                cnt = 0;
                for (int i = 0; i < n && !have; i++)
                begin
                    pos = p + i;
                    if (pos >= n)
                        pos -= n;
                    if (owner_map[pos] == 0)
                    begin
                        if (cnt == 0)
                            run_start = pos;
                        cnt++;
                        if (cnt >= r.size)
                            have = 1'b1;
                    end
                    else
                    begin
                        cnt = 0;
                    end
                end
                pick = run_start;
            end
            else
            begin
                for (int i = 0; i <= n && !done; i++)
                begin
                    free_slot = 1'b0;
                    if (i < n)
                        free_slot = (owner_map[i] == 0);
                    if (free_slot)
                    begin
                        if (run_len == 0)
                            run_start = i;
                        run_len++;
                    end
                    else
                    begin
                        if (run_len >= r.size)
                        begin
                            if (cur_policy == POL_FIRST
                                || (cur_policy == POL_BEST && run_len == r.size))
                            begin
                                pick = run_start;
                                have = 1'b1;
                                done = 1'b1;
                            end
                            else if (!have || (cur_policy == POL_BEST ? run_len < pick_len
                                                                       : run_len > pick_len))
                            begin
                                have = 1'b1;
                                pick = run_start;
                                pick_len = run_len;
                            end
                        end
                        run_len = 0;
                    end
                end
            end
            if (have)
            begin
                pos = pick;
                for (int i = 0; i < r.size; i++)
                begin
                    owner_map[pos] = r.owner;
                    pos++;
                    if (pos >= n)
                        pos = 0;
                end
                if (cur_policy == POL_NEXT)
                    fit_ptr = (pick + r.size) % n;
                res.status = ST_ALLOC;
                res.start = IDX_W'(pick);
            end
            else
            begin
                res.status = ST_NOSPACE;
            end
        end
        return res;
    endfunction

    task automatic queue_request(logic cmd, int unsigned size, int unsigned owner);
        plan_step_t s;
        s = '0;
        s.kind = STEP_REQ;
        s.item.cmd = cmd;
        s.item.size = SIZE_W'(size);
        s.item.owner = OWNER_W'(owner);
        queued_steps.push_back(s);
        if (cmd == CMD_ALLOC && owner != 0 && owner <= OWNER_IDS)
            live_owners.push_back(owner);
    endtask

    // register writes only once every reply is back
    task automatic set_register(logic [CFG_IDX_W-1:0] index, int unsigned value);
        plan_step_t s;
        s = '0;
        s.kind = STEP_DRAIN;
        queued_steps.push_back(s);
        s.kind = STEP_CFG;
        s.index = index;
        s.value = CFG_W'(value);
        queued_steps.push_back(s);
        settings_used++;
    endtask

    task automatic random_phase(logic [POL_W-1:0] pol, int unsigned slots_value, int count);
        int unsigned n;
        int unsigned lim;
        int unsigned roll;
        int unsigned pick;
        int unsigned owner;
        int unsigned size;
        set_register(REG_POLICY, ($urandom_range(0, 127) << 2) | 32'(pol));
        set_register(REG_SLOTS, slots_value);
        n = (slots_value > SLOTS) ? SLOTS : slots_value;
        lim = (n == 0) ? 1 : n;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                queue_request(1'($urandom_range(0, 1)), $urandom_range(0, 511),
                              $urandom_range(0, 255));
            end
            else if (roll < 40 && live_owners.size() > 0)
            begin
                pick = $urandom_range(0, live_owners.size() - 1);
                owner = live_owners[pick];
                live_owners.delete(pick);
                queue_request(CMD_RELEASE, $urandom_range(0, 511), owner);
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    size = $urandom_range(1, lim);
                else
                    size = $urandom_range(1, (lim + 5) / 6);
                queue_request(CMD_ALLOC, size, $urandom_range(1, OWNER_IDS));
            end
        end
    endtask

    // request side
    always @(negedge clk)
    begin : feed_requests
        logic                 offer;
        logic                 load;
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        plan_step_t           head;
        if (rst_n)
        begin
            offer = req_ch.valid && (req_taken != req_sent);
            load = 1'b0;
            we = 1'b0;
            idx = '0;
            data = '0;
            head = '0;
            if (!offer)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (queued_steps.size() > 0)
                begin
                    head = queued_steps[0];
                    case (head.kind)
                        STEP_DRAIN:
                        begin
                            if (predicted_replies.size() == 0 && req_taken == req_sent)
                                void'(queued_steps.pop_front());
                        end
                        STEP_CFG:
                        begin
                            we = 1'b1;
                            idx = head.index;
                            data = head.value;
                            void'(queued_steps.pop_front());
                        end
                        default:
                        begin
                            offer = 1'b1;
                            load = 1'b1;
                            req_sent++;
                            void'(queued_steps.pop_front());
                            if (burst_left > 0)
                                burst_left--;
                            if (burst_left == 0)
                            begin
                                burst_left = $urandom_range(1, 16);
                                case ($urandom_range(0, 9))
                                    0, 1, 2, 3: gap_left = 0;
                                    4, 5, 6, 7: gap_left = $urandom_range(1, 8);
                                    default:    gap_left = $urandom_range(20, 300);
                                endcase
                            end
                        end
                    endcase
                end
            end
            req_ch.valid <= offer;
            if (load)
            begin
                req_ch.cmd <= head.item.cmd;
                req_ch.request_size <= head.item.size;
                req_ch.owner_id <= head.item.owner;
            end
            cfg_we <= we;
            cfg_index <= idx;
            cfg_wdata <= data;
        end
    end

    // reply side
    always @(negedge clk)
    begin : pace_replies
        logic rdy;
        if (rst_n)
        begin
            rdy = 1'b0;
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else if (!hold_done && replies_seen >= 60)
            begin
                // long hold so the block fills and stalls the request side
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            else
            begin
                if (stall_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    stall_left = $urandom_range(10, 200);
                end
                stall_left--;
                case (stall_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 3) != 0);
                    2:       rdy = 1'($urandom_range(0, 1));
                    default: rdy = (stall_left % 7) < 2;
                endcase
            end
            rsp_ch.ready <= rdy;
        end
    end

    always @(posedge clk)
    begin : watch_channels
        res_t want;
        req_t taken;
        if (rst_n)
        begin
            cycle_count++;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_POLICY: cur_policy = cfg_wdata[POL_W-1:0];
                    REG_SLOTS:  cur_slots = cfg_wdata;
                    default:    ;
                endcase
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                replies_seen++;
                if (predicted_replies.size() == 0)
                begin
                    $error("unexpected reply: status %0d start_slot %0d",
                           rsp_ch.status, rsp_ch.start_slot);
                    mismatches++;
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, rsp_ch.status);
                        mismatches++;
                    end
                    if (rsp_ch.start_slot !== want.start)
                    begin
                        $error("start_slot mismatch: expected %0d, actual %0d",
                               want.start, rsp_ch.start_slot);
                        mismatches++;
                    end
                    case (want.status)
                        ST_ALLOC:    n_granted++;
                        ST_NOSPACE:  n_nospace++;
                        ST_RELEASED: n_released++;
                        default:     n_notfound++;
                    endcase
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                taken.cmd = req_ch.cmd;
                taken.size = req_ch.request_size;
                taken.owner = req_ch.owner_id;
                predicted_replies.push_back(serve_request(taken));
                req_taken++;
            end
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d replies outstanding",
                         cycle_count, predicted_replies.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_ALLOC;
        req_ch.request_size = '0;
        req_ch.owner_id = '0;
        rsp_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        foreach (owner_map[i])
            owner_map[i] = '0;
        fit_ptr = 0;
        cur_policy = POL_FIRST;
        cur_slots = SLOTS_IN_USE_RESET;
        req_sent = 0;
        req_taken = 0;
        replies_seen = 0;
        settings_used = 0;
        mismatches = 0;
        cycle_count = 0;
        n_granted = 0;
        n_nospace = 0;
        n_released = 0;
        n_notfound = 0;
        burst_left = 0;
        gap_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        stall_left = 0;
        stall_mode = 0;

        // whole map as one run, then free it
        queue_request(CMD_ALLOC, 256, 200);
        queue_request(CMD_RELEASE, 0, 200);
        // zero size, oversize, invalid owner, absent owner
        queue_request(CMD_ALLOC, 0, 1);
        queue_request(CMD_ALLOC, 257, 1);
        queue_request(CMD_ALLOC, 511, 2);
        queue_request(CMD_ALLOC, 4, 0);
        queue_request(CMD_RELEASE, 0, 0);
        queue_request(CMD_RELEASE, 0, 9);
        // first fit refills the lowest hole
        queue_request(CMD_ALLOC, 10, 1);
        queue_request(CMD_ALLOC, 20, 255);
        queue_request(CMD_ALLOC, 5, 128);
        queue_request(CMD_RELEASE, 0, 255);
        queue_request(CMD_ALLOC, 3, 3);
        // best fit, exact hole, then worst fit
        set_register(REG_POLICY, 32'(POL_BEST));
        queue_request(CMD_ALLOC, 17, 4);
        queue_request(CMD_ALLOC, 1, 5);
        set_register(REG_POLICY, 9'h1FE);
        queue_request(CMD_ALLOC, 2, 6);
        // no managed slots, then a single one
        set_register(REG_SLOTS, 0);
        queue_request(CMD_ALLOC, 1, 6);
        queue_request(CMD_RELEASE, 0, 1);
        set_register(REG_SLOTS, 1);
        queue_request(CMD_ALLOC, 1, 7);
        queue_request(CMD_RELEASE, 0, 1);
        queue_request(CMD_ALLOC, 1, 7);
        // next fit on eight slots, run wrapping past the last slot
        set_register(REG_SLOTS, 8);
        set_register(REG_POLICY, 9'h1FF);
        set_register(REG_SPARE_A, 9'h1FF);
        set_register(REG_SPARE_B, 9'h0AA);
        queue_request(CMD_RELEASE, 0, 1);
        queue_request(CMD_ALLOC, 5, 10);
        queue_request(CMD_ALLOC, 3, 11);
        queue_request(CMD_RELEASE, 0, 7);
        queue_request(CMD_ALLOC, 3, 11);

        random_phase(POL_BEST, 16, 48);
        random_phase(POL_NEXT, 24, 48);
        random_phase(POL_WORST, 256, 48);
        random_phase(POL_NEXT, 6, 48);
        random_phase(POL_FIRST, 64, 48);
        random_phase(POL_NEXT, 511, 48);
        random_phase(POL_BEST, 200, 48);
        random_phase(POL_WORST, 3, 48);
        random_phase(POL_FIRST, 0, 10);
        random_phase(POL_NEXT, 256, 48);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (queued_steps.size() != 0 || req_taken != req_sent
               || predicted_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_LIMIT) @(posedge clk);

        $display("%0d requests over %0d register writes in %0d cycles", req_taken,
                 settings_used, cycle_count);
        $display("replies: %0d granted, %0d no space, %0d released, %0d owner not found",
                 n_granted, n_nospace, n_released, n_notfound);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
rtl/csa_pkg.sv
rtl/csa_if.sv
rtl/csa_slot_mem.sv
rtl/csa_ctrl.sv
rtl/contiguous_slot_allocator_core.sv
rtl/csa_checker.sv
tb/sv/contiguous_slot_allocator_core_tb.sv
